// ===== design/gvr_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Givens rotation sequence.
// No dependencies; gvr_cordic, the top level and the checker use it through scoped names.
`default_nettype none

package gvr_pkg;

  localparam int unsigned MAX_SIZE_DEF     = 8;
  localparam int unsigned CORDIC_STEPS_DEF = 20;

  localparam int unsigned ELEM_W  = 24;  // stored element, Q2.22
  localparam int unsigned OUT_W   = 18;  // emitted element, Q2.16
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned SIZE_W  = 4;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned CXY_W   = 34;  // CORDIC x and y at 2^-30
  localparam int unsigned CZ_W    = 33;  // CORDIC angle residue at 2^-30
  localparam int unsigned PROD_W  = 2 * ELEM_W;

  localparam logic signed [ELEM_W-1:0] ONE_Q22     = 24'sd4194304;
  localparam logic signed [CXY_W-1:0]  CORDIC_GAIN = 34'sd652032874;
  localparam logic [32:0]              TWO_PI_Q30  = 33'd6746518852;
  localparam logic signed [OUT_W-1:0]  OUT_POS_ONE = 18'sd65536;
  localparam logic signed [OUT_W-1:0]  OUT_NEG_ONE = -18'sd65536;
  localparam logic [ANGLE_W-1:0]       HALF_TURN   = 16'd32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_RD_A,
    ST_RD_B,
    ST_MUL_I,
    ST_WR_I,
    ST_WR_J,
    ST_NEXT,
    ST_E_RD,
    ST_E_LOAD,
    ST_E_OUT,
    ST_ONE_OUT
  } state_t;

  // Arctangent of 2^-k at 2^-30 rad
  function automatic logic signed [CZ_W-1:0] atan_lookup(input logic [4:0] k);
    logic signed [CZ_W-1:0] v;
    case (k)
      5'd0:    v = 33'sh03243F6A8;
      5'd1:    v = 33'sh01DAC6705;
      5'd2:    v = 33'sh00FADBAFC;
      5'd3:    v = 33'sh007F56EA6;
      5'd4:    v = 33'sh003FEAB76;
      5'd5:    v = 33'sh001FFD55B;
      5'd6:    v = 33'sh000FFFAAA;
      5'd7:    v = 33'sh0007FFF55;
      5'd8:    v = 33'sh0003FFFEA;
      5'd9:    v = 33'sh0001FFFFD;
      5'd10:   v = 33'sh0000FFFFF;
      5'd11:   v = 33'sh00007FFFF;
      5'd12:   v = 33'sh00003FFFF;
      5'd13:   v = 33'sh00001FFFF;
      5'd14:   v = 33'sh00000FFFF;
      5'd15:   v = 33'sh000007FFF;
      5'd16:   v = 33'sh000003FFF;
      5'd17:   v = 33'sh000001FFF;
      5'd18:   v = 33'sh000000FFF;
      5'd19:   v = 33'sh0000007FF;
      5'd20:   v = 33'sh0000003FF;
      5'd21:   v = 33'sh0000001FF;
      5'd22:   v = 33'sh0000000FF;
      5'd23:   v = 33'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round a CORDIC coordinate to Q2.22 and clamp to +-1
  function automatic logic signed [ELEM_W-1:0] cordic_to_q22(input logic signed [CXY_W-1:0] v);
    logic signed [CXY_W-1:0] r;
    r = (v + 34'sd128) >>> 8;
    if (r > 34'sd4194304) return ONE_Q22;
    if (r < -34'sd4194304) return -ONE_Q22;
    return r[ELEM_W-1:0];
  endfunction

  // Round a product sum by 22 bits and saturate to the element range
  function automatic logic signed [ELEM_W-1:0] mix(input logic signed [PROD_W:0] s);
    logic signed [PROD_W+1:0] r;
    r = ($signed({s[PROD_W], s}) + 50'sd2097152) >>> 22;
    if (r > 50'sd8388607) return 24'sh7FFFFF;
    if (r < -50'sd8388608) return 24'sh800000;
    return r[ELEM_W-1:0];
  endfunction

  // Round Q2.22 to Q2.16 and saturate to +-1, one guard bit for the rounding add
  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [ELEM_W-1:0] e);
    logic signed [ELEM_W:0] r;
    r = ($signed({e[ELEM_W-1], e}) + 25'sd32) >>> 6;
    if (r > 25'sd65536) return OUT_POS_ONE;
    if (r < -25'sd65536) return OUT_NEG_ONE;
    return r[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/gvr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module gvr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/gvr_cordic.sv =====
// Iterative rotation-mode CORDIC giving cosine and sine of a 16-bit turn fraction.
// Depends on gvr_pkg.
`default_nettype none

module gvr_cordic #(
  parameter int unsigned CORDIC_STEPS = gvr_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic [gvr_pkg::ANGLE_W-1:0]         angle,
  output logic                                     done,
  output logic signed [gvr_pkg::ELEM_W-1:0]        cos_q,
  output logic signed [gvr_pkg::ELEM_W-1:0]        sin_q
);

  logic                              busy_r;
  logic [4:0]                        step_r;
  logic [1:0]                        quad_r;
  logic signed [gvr_pkg::CXY_W-1:0]  x_r, y_r;
  logic signed [gvr_pkg::CZ_W-1:0]   z_r;
  logic                              done_r;
  logic signed [gvr_pkg::ELEM_W-1:0] cos_r, sin_r;
  logic [46:0]                       z_scaled;
  logic signed [gvr_pkg::CXY_W-1:0]  dx, dy;
  logic signed [gvr_pkg::ELEM_W-1:0] c_q, s_q;

  // Scale the in-quadrant residue to radians
  assign z_scaled = 47'(angle[13:0]) * 47'(gvr_pkg::TWO_PI_Q30);

  assign dx  = y_r >>> step_r;
  assign dy  = x_r >>> step_r;
  assign c_q = gvr_pkg::cordic_to_q22(x_r);
  assign s_q = gvr_pkg::cordic_to_q22(y_r);

  // Control: one micro-rotation per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == 5'(CORDIC_STEPS)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 5'd1;
        end
      end
    end
  end

  // Datapath: rotate, then round and map the quadrant
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= gvr_pkg::CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= gvr_pkg::CZ_W'(z_scaled >> 16);
      quad_r <= angle[15:14];
    end else if (busy_r) begin
      if (step_r != 5'(CORDIC_STEPS)) begin
        if (!z_r[gvr_pkg::CZ_W-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - gvr_pkg::atan_lookup(step_r);
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + gvr_pkg::atan_lookup(step_r);
        end
      end else begin
        case (quad_r)
          2'd0: begin cos_r <= c_q;  sin_r <= s_q;  end
          2'd1: begin cos_r <= -s_q; sin_r <= c_q;  end
          2'd2: begin cos_r <= -c_q; sin_r <= -s_q; end
          default: begin cos_r <= s_q; sin_r <= -c_q; end
        endcase
      end
    end
  end

  assign done  = done_r;
  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

`default_nettype wire

// ===== design/givens_rotation_sequence.sv =====
// Top level of the Givens rotation sequence: sequencer, matrix store and output stage.
// Depends on gvr_pkg, gvr_ram and gvr_cordic.
//
// Usage: write the rank n to cfg_data (cfg_valid/cfg_ready) while idle; this
// restarts the sequence from the identity. Each angle on in_angle
// (in_valid/in_stall) applies one plane rotation to rows (i,j), pairs taken
// with i outer, j inner. Angles produce no results until the n*(n-1)-th one,
// after which the n*n elements leave on out_* in column order, out_last on
// the final one, and the store returns to the identity.
// Each angle first runs through the CORDIC; then, per column, states RD_A,
// RD_B, MUL_I, WR_I and WR_J read, rotate and write back both rows through
// the store's separate read and write ports, and ST_NEXT advances the pair.
// Emission passes each element through E_RD, E_LOAD and E_OUT. A rank of
// one answers every angle with one element.
// in_stall stays high while an angle is in work or results are pending;
// out_stall simply holds the current element. Reset selects rank 2, the
// identity matrix and pair (0,1); the store needs no clearing pass.
`default_nettype none

module givens_rotation_sequence #(
  parameter int unsigned MAX_SIZE     = gvr_pkg::MAX_SIZE_DEF,
  parameter int unsigned CORDIC_STEPS = gvr_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [gvr_pkg::SIZE_W-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [gvr_pkg::ANGLE_W-1:0]       in_angle,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [gvr_pkg::OUT_W-1:0]       out_element,
  output logic [gvr_pkg::POS_W-1:0]              out_row,
  output logic [gvr_pkg::POS_W-1:0]              out_column,
  output logic                                   out_last
);

  localparam int unsigned IDX_W  = $clog2(MAX_SIZE);
  localparam int unsigned ADDR_W = 2 * IDX_W;
  localparam int unsigned DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int unsigned CNT_W  = IDX_W + 2;

  gvr_pkg::state_t state_r, state_nxt;

  logic [gvr_pkg::SIZE_W-1:0]          size_r;
  logic [CNT_W-1:0]                    n_w;
  logic [IDX_W-1:0]                    i_r, j_r, k_r, r_r, c_r;
  logic [DEPTH-1:0]                    vld_r;
  logic                                rd_vld_r;
  logic [ADDR_W-1:0]                   rd_addr_r;
  logic signed [gvr_pkg::ELEM_W-1:0]   a_r, b_r, eff;
  logic signed [gvr_pkg::PROD_W-1:0]   p1_r, p2_r, p1_nxt, p2_nxt;
  logic signed [gvr_pkg::OUT_W-1:0]    elem_r;
  logic [IDX_W-1:0]                    orow_r, ocol_r;
  logic                                olast_r;

  logic                                ram_we;
  logic [ADDR_W-1:0]                   ram_waddr, ram_raddr;
  logic [gvr_pkg::ELEM_W-1:0]          ram_wdata, ram_q;
  logic                                cordic_start, cordic_done;
  logic signed [gvr_pkg::ELEM_W-1:0]   cs, sn;

  logic                                in_acc, cfg_acc, out_acc, rank_one;
  logic                                k_last, e_last;
  logic [CNT_W-1:0]                    j_step, j_adv, i_adv;
  logic                                pairs_done;

  // Rank with out-of-range codes folded in
  always_comb begin
    if (size_r == '0) n_w = CNT_W'(1);
    else if (size_r > gvr_pkg::SIZE_W'(MAX_SIZE)) n_w = CNT_W'(MAX_SIZE);
    else n_w = CNT_W'(size_r);
  end

  assign rank_one = (n_w == CNT_W'(1));
  assign in_acc   = in_valid && !in_stall;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign out_acc  = out_valid && !out_stall;
  assign k_last   = (CNT_W'(k_r) == n_w - CNT_W'(1));
  assign e_last   = (CNT_W'(r_r) == n_w - CNT_W'(1)) && (CNT_W'(c_r) == n_w - CNT_W'(1));

  // Next pair: skip the diagonal, wrap j into the next outer row
  always_comb begin
    j_step = CNT_W'(j_r) + CNT_W'(1);
    if (j_step == CNT_W'(i_r)) j_step = j_step + CNT_W'(1);
    if (j_step >= n_w) begin
      i_adv = CNT_W'(i_r) + CNT_W'(1);
      j_adv = '0;
    end else begin
      i_adv = CNT_W'(i_r);
      j_adv = j_step;
    end
    pairs_done = (i_adv >= n_w);
  end

  // Element as stored, with unwritten entries reading as the identity
  always_comb begin
    if (rd_vld_r) eff = ram_q;
    else if (rd_addr_r[IDX_W-1:0] == rd_addr_r[ADDR_W-1:IDX_W]) eff = gvr_pkg::ONE_Q22;
    else eff = '0;
  end

  // Shared multipliers: row i terms first, then row j terms
  always_comb begin
    if (state_r == gvr_pkg::ST_MUL_I) begin
      p1_nxt = cs * a_r;
      p2_nxt = sn * eff;
    end else begin
      p1_nxt = sn * a_r;
      p2_nxt = cs * b_r;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gvr_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = rank_one ? gvr_pkg::ST_ONE_OUT : gvr_pkg::ST_CORDIC;
      end
      gvr_pkg::ST_CORDIC: if (cordic_done) state_nxt = gvr_pkg::ST_RD_A;
      gvr_pkg::ST_RD_A:   state_nxt = gvr_pkg::ST_RD_B;
      gvr_pkg::ST_RD_B:   state_nxt = gvr_pkg::ST_MUL_I;
      gvr_pkg::ST_MUL_I:  state_nxt = gvr_pkg::ST_WR_I;
      gvr_pkg::ST_WR_I:   state_nxt = gvr_pkg::ST_WR_J;
      gvr_pkg::ST_WR_J:   state_nxt = k_last ? gvr_pkg::ST_NEXT : gvr_pkg::ST_RD_A;
      gvr_pkg::ST_NEXT:   state_nxt = pairs_done ? gvr_pkg::ST_E_RD : gvr_pkg::ST_IDLE;
      gvr_pkg::ST_E_RD:   state_nxt = gvr_pkg::ST_E_LOAD;
      gvr_pkg::ST_E_LOAD: state_nxt = gvr_pkg::ST_E_OUT;
      gvr_pkg::ST_E_OUT: begin
        if (out_acc) state_nxt = olast_r ? gvr_pkg::ST_IDLE : gvr_pkg::ST_E_RD;
      end
      gvr_pkg::ST_ONE_OUT: if (out_acc) state_nxt = gvr_pkg::ST_IDLE;
      default: state_nxt = gvr_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshakes and store access
  always_comb begin
    in_stall     = (state_r != gvr_pkg::ST_IDLE);
    cfg_ready    = (state_r == gvr_pkg::ST_IDLE);
    out_valid    = (state_r == gvr_pkg::ST_E_OUT) || (state_r == gvr_pkg::ST_ONE_OUT);
    cordic_start = in_acc && !rank_one;
    ram_we       = 1'b0;
    ram_waddr    = {k_r, i_r};
    ram_wdata    = gvr_pkg::mix({p1_r[gvr_pkg::PROD_W-1], p1_r} - {p2_r[gvr_pkg::PROD_W-1], p2_r});
    ram_raddr    = {k_r, i_r};
    case (state_r)
      gvr_pkg::ST_RD_B: ram_raddr = {k_r, j_r};
      gvr_pkg::ST_WR_I: ram_we = 1'b1;
      gvr_pkg::ST_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = {k_r, j_r};
        ram_wdata = gvr_pkg::mix({p1_r[gvr_pkg::PROD_W-1], p1_r} +
                                 {p2_r[gvr_pkg::PROD_W-1], p2_r});
      end
      gvr_pkg::ST_E_RD: ram_raddr = {c_r, r_r};
      default: ;
    endcase
  end

  // Control registers: state, rank, pair and column counters, valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gvr_pkg::ST_IDLE;
      size_r  <= gvr_pkg::SIZE_W'(2);
      i_r     <= '0;
      j_r     <= IDX_W'(1);
      k_r     <= '0;
      r_r     <= '0;
      c_r     <= '0;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        size_r <= cfg_data;
        vld_r  <= '0;
        i_r    <= '0;
        j_r    <= IDX_W'(1);
      end
      if (in_acc) k_r <= '0;
      if (ram_we) vld_r[ram_waddr] <= 1'b1;
      if (state_r == gvr_pkg::ST_WR_J) k_r <= k_r + IDX_W'(1);
      if (state_r == gvr_pkg::ST_NEXT) begin
        r_r <= '0;
        c_r <= '0;
        if (!pairs_done) begin
          i_r <= IDX_W'(i_adv);
          j_r <= IDX_W'(j_adv);
        end
      end
      if (state_r == gvr_pkg::ST_E_OUT && out_acc) begin
        if (olast_r) begin
          vld_r <= '0;
          i_r   <= '0;
          j_r   <= IDX_W'(1);
        end else if (CNT_W'(r_r) == n_w - CNT_W'(1)) begin
          r_r <= '0;
          c_r <= c_r + IDX_W'(1);
        end else begin
          r_r <= r_r + IDX_W'(1);
        end
      end
    end
  end

  // Datapath registers: read tags, operands, products and output payload
  always_ff @(posedge clk) begin
    rd_vld_r  <= vld_r[ram_raddr];
    rd_addr_r <= ram_raddr;
    if (state_r == gvr_pkg::ST_RD_B) a_r <= eff;
    if (state_r == gvr_pkg::ST_MUL_I) b_r <= eff;
    if (state_r == gvr_pkg::ST_MUL_I || state_r == gvr_pkg::ST_WR_I) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (state_r == gvr_pkg::ST_IDLE && in_acc) begin
      elem_r  <= (in_angle > gvr_pkg::HALF_TURN) ? gvr_pkg::OUT_POS_ONE : gvr_pkg::OUT_NEG_ONE;
      orow_r  <= '0;
      ocol_r  <= '0;
      olast_r <= 1'b1;
    end
    if (state_r == gvr_pkg::ST_E_LOAD) begin
      elem_r  <= gvr_pkg::to_out(eff);
      orow_r  <= r_r;
      ocol_r  <= c_r;
      olast_r <= e_last;
    end
  end

  assign out_element = elem_r;
  assign out_row     = gvr_pkg::POS_W'(orow_r);
  assign out_column  = gvr_pkg::POS_W'(ocol_r);
  assign out_last    = olast_r;

  gvr_ram #(
    .WIDTH (gvr_pkg::ELEM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  gvr_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (in_angle),
    .done  (cordic_done),
    .cos_q (cs),
    .sin_q (sn)
  );

endmodule

`default_nettype wire

// ===== design/gvr_checker.sv =====
// Port-level assertions for the Givens rotation sequence, bound to the top level.
// Depends on gvr_pkg and givens_rotation_sequence.
`default_nettype none

module gvr_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               cfg_ready,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic signed [gvr_pkg::OUT_W-1:0]   out_element,
  input wire logic                               out_last
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_element) && $stable(out_last))
    else $error("stalled output changed");

  // Take no angle while a result is pending
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while output pending");

  // Refuse configuration while busy
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !cfg_ready)
    else $error("configuration ready while busy");

  // Keep elements within plus or minus one
  a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_element <= gvr_pkg::OUT_POS_ONE) && (out_element >= gvr_pkg::OUT_NEG_ONE))
    else $error("element out of range");

endmodule

bind givens_rotation_sequence gvr_checker u_gvr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .cfg_ready   (cfg_ready),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_element (out_element),
  .out_last    (out_last)
);

`default_nettype wire
